// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define TJMS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is followed by an outcome in the next cycle.
`define TJMS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/tjms_pkg.sv =====
package tjms_pkg;

	// Field widths fixed by the item format
	localparam int CMD_W      = 4;
	localparam int SEL_W      = 2;
	localparam int STATUS_W   = 3;
	localparam int MODE_W     = 2;
	localparam int FLAG_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int MAX_STEP_W = 23;

	localparam logic [MAX_STEP_W-1:0] MAX_STEP_RESET = {MAX_STEP_W{1'b1}};

	// Command codes
	localparam logic [CMD_W-1:0] CMD_TICK        = 4'd0;
	localparam logic [CMD_W-1:0] CMD_OPEN        = 4'd1;
	localparam logic [CMD_W-1:0] CMD_CLOSE       = 4'd2;
	localparam logic [CMD_W-1:0] CMD_ENABLE      = 4'd3;
	localparam logic [CMD_W-1:0] CMD_DISABLE     = 4'd4;
	localparam logic [CMD_W-1:0] CMD_HOME        = 4'd5;
	localparam logic [CMD_W-1:0] CMD_JOG         = 4'd6;
	localparam logic [CMD_W-1:0] CMD_STOP        = 4'd7;
	localparam logic [CMD_W-1:0] CMD_ESTOP       = 4'd8;
	localparam logic [CMD_W-1:0] CMD_RESET_ESTOP = 4'd9;
	localparam logic [CMD_W-1:0] CMD_CLEAR_ALARM = 4'd10;

	// Axis modes
	localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MOVING = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ALARM  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_ESTOP  = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_ESTOP    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_DISABLED = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_ALARM    = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_STEP     = 3'd4;

	// Soft limit flag and fault codes
	localparam logic [FLAG_W-1:0] LIM_NONE = 2'd0;
	localparam logic [FLAG_W-1:0] LIM_POS  = 2'd1;
	localparam logic [FLAG_W-1:0] LIM_NEG  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 3'd6;

	typedef enum logic [1:0] {
		S_IDLE,
		S_APPLY,
		S_EMIT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_APPLY,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [CMD_W-1:0] cmd;
		logic             last;
	} dp_cmd_t;

endpackage

// ===== sv/tjms_if.sv =====
interface tjms_in_if #(
	parameter int STEP_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic [tjms_pkg::CMD_W-1:0]    cmd;
	logic [tjms_pkg::SEL_W-1:0]    axis_sel;
	logic signed [STEP_WIDTH-1:0]  jog_step;

	modport source (output valid, cmd, axis_sel, jog_step, input ready);
	modport sink (input valid, cmd, axis_sel, jog_step, output ready);
endinterface

interface tjms_out_if #(
	parameter int POS_WIDTH  = 32,
	parameter int STEP_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic [tjms_pkg::STATUS_W-1:0] status;
	logic [tjms_pkg::SEL_W-1:0]    axis_id;
	logic [tjms_pkg::MODE_W-1:0]   axis_mode;
	logic signed [POS_WIDTH-1:0]   position;
	logic signed [STEP_WIDTH-1:0]  velocity;
	logic [tjms_pkg::FLAG_W-1:0]   limit_flag;
	logic [tjms_pkg::FLAG_W-1:0]   fault_code;
	logic                          enabled;
	logic                          homed;
	logic                          estop_flag;
	logic                          last_of_run;

	modport source (output valid, status, axis_id, axis_mode, position, velocity,
		limit_flag, fault_code, enabled, homed, estop_flag, last_of_run, input ready);
	modport sink (input valid, status, axis_id, axis_mode, position, velocity,
		limit_flag, fault_code, enabled, homed, estop_flag, last_of_run, output ready);
endinterface

// ===== sv/tjms_ctrl.sv =====
`include "assert_macros.svh"

module tjms_ctrl #(
	parameter int NUM_AXES = 3,
	parameter int IDX_W    = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [tjms_pkg::CMD_W-1:0] in_cmd,
	input  logic [tjms_pkg::SEL_W-1:0] in_sel,
	output logic                       out_valid,
	input  logic                       out_ready,
	output tjms_pkg::dp_cmd_t          dp_cmd,
	output logic [IDX_W-1:0]           axis_idx
);
	import tjms_pkg::*;

	ctrl_state_t      state_q, state_nxt;
	logic [IDX_W-1:0] idx_q;
	logic [CMD_W-1:0] cmd_q;
	logic             peraxis_q;
	logic             out_valid_q;

	logic accept;
	logic is_bcast;
	logic is_peraxis;
	logic item_ok;
	logic slot_free;
	logic last_c;
	logic emit;

	// Decode the incoming command
	always_comb begin
		is_bcast   = in_cmd inside {CMD_TICK, CMD_OPEN, CMD_CLOSE, CMD_ESTOP, CMD_RESET_ESTOP};
		is_peraxis = in_cmd inside {CMD_ENABLE, CMD_DISABLE, CMD_HOME, CMD_JOG, CMD_STOP,
			CMD_CLEAR_ALARM};
		item_ok    = is_bcast || (is_peraxis && (int'(in_sel) < NUM_AXES));
	end

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign last_c    = peraxis_q || (idx_q == IDX_W'(NUM_AXES - 1));
	assign emit      = (state_q == S_EMIT) && slot_free;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && item_ok)
					state_nxt = (in_cmd == CMD_TICK) ? S_EMIT : S_APPLY;
			end
			S_APPLY: state_nxt = S_EMIT;
			S_EMIT: begin
				if (slot_free && last_c)
					state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Datapath command
	always_comb begin
		dp_cmd.cmd  = cmd_q;
		dp_cmd.last = last_c;
		case (state_q)
			S_IDLE:  dp_cmd.op = accept ? OP_CAPTURE : OP_NONE;
			S_APPLY: dp_cmd.op = OP_APPLY;
			S_EMIT:  dp_cmd.op = slot_free ? OP_EMIT : OP_NONE;
			default: dp_cmd.op = OP_NONE;
		endcase
	end

	assign axis_idx  = idx_q;
	assign out_valid = out_valid_q;

	// Hold the item's command, walk the axis index, track the result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			cmd_q       <= CMD_TICK;
			peraxis_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				cmd_q     <= in_cmd;
				peraxis_q <= is_peraxis;
				idx_q     <= is_peraxis ? IDX_W'(in_sel) : '0;
			end else if (emit && !last_c) begin
				idx_q <= idx_q + 1'b1;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	`TJMS_ASSERT(a_no_overwrite, clk, arst_n, (out_valid && !out_ready) |-> (dp_cmd.op != OP_EMIT), "result beat overwritten before it was taken")
	`TJMS_ASSERT_NEXT(a_last_ends_run, clk, arst_n, dp_cmd.op == OP_EMIT && dp_cmd.last, state_q == S_IDLE, "controller did not return to idle after the last beat")
	`TJMS_ASSERT_NEXT(a_apply_then_emit, clk, arst_n, state_q == S_APPLY, state_q == S_EMIT, "command update not followed by emit")
	`TJMS_ASSERT(a_valid_from_emit, clk, arst_n, $rose(out_valid) |-> $past(dp_cmd.op == OP_EMIT), "result valid raised without an emit")

endmodule

// ===== sv/tjms_dp.sv =====
module tjms_dp #(
	parameter int NUM_AXES   = 3,
	parameter int POS_WIDTH  = 32,
	parameter int STEP_WIDTH = 24,
	parameter int IDX_W      = 2,
	parameter int CFG_W      = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tjms_pkg::dp_cmd_t               dp_cmd,
	input  logic [IDX_W-1:0]                axis_idx,
	input  logic signed [STEP_WIDTH-1:0]    in_step,
	input  logic                            cfg_we,
	input  logic [tjms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]                cfg_data,
	output logic [tjms_pkg::STATUS_W-1:0]   o_status,
	output logic [tjms_pkg::SEL_W-1:0]      o_axis,
	output logic [tjms_pkg::MODE_W-1:0]     o_mode,
	output logic signed [POS_WIDTH-1:0]     o_pos,
	output logic signed [STEP_WIDTH-1:0]    o_vel,
	output logic [tjms_pkg::FLAG_W-1:0]     o_limit,
	output logic [tjms_pkg::FLAG_W-1:0]     o_fault,
	output logic                            o_enabled,
	output logic                            o_homed,
	output logic                            o_estop,
	output logic                            o_last
);
	import tjms_pkg::*;

	localparam int SUM_W = ((POS_WIDTH > STEP_WIDTH) ? POS_WIDTH : STEP_WIDTH) + 1;
	localparam int MAG_W = (STEP_WIDTH + 1 > MAX_STEP_W) ? STEP_WIDTH + 1 : MAX_STEP_W;
	localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
	localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};

	// Axis records
	logic signed [POS_WIDTH-1:0]  pos_q   [NUM_AXES];
	logic signed [STEP_WIDTH-1:0] jog_q   [NUM_AXES];
	logic signed [STEP_WIDTH-1:0] rep_q   [NUM_AXES];
	logic [MODE_W-1:0]            mode_q  [NUM_AXES];
	logic                         en_q    [NUM_AXES];
	logic                         homed_q [NUM_AXES];
	logic [FLAG_W-1:0]            lim_q   [NUM_AXES];
	logic [FLAG_W-1:0]            fault_q [NUM_AXES];
	logic                         estop_q;
	logic                         open_q;

	// Soft limits and step bound
	logic signed [POS_WIDTH-1:0]  lim_lo_q [NUM_AXES];
	logic signed [POS_WIDTH-1:0]  lim_hi_q [NUM_AXES];
	logic [MAX_STEP_W-1:0]        max_step_q;

	logic signed [STEP_WIDTH-1:0] step_q;
	logic [STATUS_W-1:0]          status_q;

	// Output register
	logic [STATUS_W-1:0]          o_status_q;
	logic [SEL_W-1:0]             o_axis_q;
	logic [MODE_W-1:0]            o_mode_q;
	logic signed [POS_WIDTH-1:0]  o_pos_q;
	logic signed [STEP_WIDTH-1:0] o_vel_q;
	logic [FLAG_W-1:0]            o_limit_q;
	logic [FLAG_W-1:0]            o_fault_q;
	logic                         o_enabled_q;
	logic                         o_homed_q;
	logic                         o_estop_q;
	logic                         o_last_q;

	logic signed [POS_WIDTH-1:0]  cur_pos;
	logic signed [STEP_WIDTH-1:0] cur_jog;
	logic [MODE_W-1:0]            cur_mode;
	logic signed [SUM_W-1:0]      sum;
	logic                         over;
	logic                         under;
	logic                         tick_go;
	logic [STEP_WIDTH:0]          step_wide;
	logic [STEP_WIDTH:0]          step_abs;
	logic                         step_big;
	logic [STATUS_W-1:0]          safety;
	logic [STATUS_W-1:0]          apply_status;

	logic signed [POS_WIDTH-1:0]  nxt_pos;
	logic signed [STEP_WIDTH-1:0] nxt_jog;
	logic signed [STEP_WIDTH-1:0] nxt_rep;
	logic [MODE_W-1:0]            nxt_mode;
	logic [FLAG_W-1:0]            nxt_lim;
	logic [FLAG_W-1:0]            nxt_fault;

	assign cur_pos  = pos_q[axis_idx];
	assign cur_jog  = jog_q[axis_idx];
	assign cur_mode = mode_q[axis_idx];

	// Advance the selected axis by one tick and test its soft limits
	always_comb begin
		sum     = SUM_W'(cur_pos) + SUM_W'(cur_jog);
		over    = sum > SUM_W'(lim_hi_q[axis_idx]);
		under   = sum < SUM_W'(lim_lo_q[axis_idx]);
		tick_go = (dp_cmd.cmd == CMD_TICK) && open_q && (cur_mode == MODE_MOVING);

		nxt_pos   = cur_pos;
		nxt_jog   = cur_jog;
		nxt_rep   = rep_q[axis_idx];
		nxt_mode  = cur_mode;
		nxt_lim   = lim_q[axis_idx];
		nxt_fault = fault_q[axis_idx];
		if (tick_go) begin
			if (over || under) begin
				nxt_jog   = '0;
				nxt_rep   = '0;
				nxt_mode  = MODE_ALARM;
				nxt_lim   = over ? LIM_POS : LIM_NEG;
				nxt_fault = over ? LIM_POS : LIM_NEG;
			end else begin
				nxt_pos = POS_WIDTH'(sum);
				nxt_rep = cur_jog;
			end
		end
	end

	// Safety checks and step bound for per-axis commands
	always_comb begin
		step_wide = {step_q[STEP_WIDTH-1], step_q};
		step_abs  = step_q[STEP_WIDTH-1] ? (~step_wide + 1'b1) : step_wide;
		step_big  = MAG_W'(step_abs) > MAG_W'(max_step_q);

		if (estop_q)
			safety = STAT_ESTOP;
		else if (!en_q[axis_idx])
			safety = STAT_DISABLED;
		else if (cur_mode == MODE_ALARM)
			safety = STAT_ALARM;
		else
			safety = STAT_OK;

		case (dp_cmd.cmd)
			CMD_ENABLE: apply_status = estop_q ? STAT_ESTOP : STAT_OK;
			CMD_HOME:   apply_status = safety;
			CMD_JOG: begin
				if (step_q == '0)
					apply_status = STAT_OK;
				else if (safety != STAT_OK)
					apply_status = safety;
				else
					apply_status = step_big ? STAT_STEP : STAT_OK;
			end
			default:    apply_status = STAT_OK;
		endcase
	end

	// Update records on capture, command and emit; take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				pos_q[i]    <= '0;
				jog_q[i]    <= '0;
				rep_q[i]    <= '0;
				mode_q[i]   <= MODE_IDLE;
				en_q[i]     <= 1'b0;
				homed_q[i]  <= 1'b0;
				lim_q[i]    <= LIM_NONE;
				fault_q[i]  <= LIM_NONE;
				lim_lo_q[i] <= POS_MIN;
				lim_hi_q[i] <= POS_MAX;
			end
			estop_q    <= 1'b0;
			open_q     <= 1'b0;
			max_step_q <= MAX_STEP_RESET;
			step_q     <= '0;
			status_q   <= STAT_OK;
		end else begin
			// register writes
			if (cfg_we) begin
				if (cfg_index == REG_MAX_STEP)
					max_step_q <= cfg_data[MAX_STEP_W-1:0];
				for (int i = 0; i < NUM_AXES; i++) begin
					if (cfg_index < REG_MAX_STEP && int'(cfg_index[CFG_IDX_W-1:1]) == i) begin
						if (cfg_index[0])
							lim_hi_q[i] <= POS_WIDTH'(cfg_data);
						else
							lim_lo_q[i] <= POS_WIDTH'(cfg_data);
					end
				end
			end

			case (dp_cmd.op)
				OP_CAPTURE: begin
					step_q   <= in_step;
					status_q <= STAT_OK;
				end
				OP_APPLY: begin
					status_q <= apply_status;
					case (dp_cmd.cmd)
						CMD_OPEN: begin
							if (!open_q) begin
								open_q  <= 1'b1;
								estop_q <= 1'b0;
								for (int i = 0; i < NUM_AXES; i++)
									en_q[i] <= 1'b1;
							end
						end
						CMD_CLOSE: open_q <= 1'b0;
						CMD_ESTOP: begin
							estop_q <= 1'b1;
							for (int i = 0; i < NUM_AXES; i++) begin
								jog_q[i]  <= '0;
								rep_q[i]  <= '0;
								mode_q[i] <= MODE_ESTOP;
							end
						end
						CMD_RESET_ESTOP: begin
							if (estop_q) begin
								estop_q <= 1'b0;
								for (int i = 0; i < NUM_AXES; i++)
									mode_q[i] <= MODE_IDLE;
							end
						end
						CMD_ENABLE: begin
							if (!estop_q)
								en_q[axis_idx] <= 1'b1;
						end
						CMD_DISABLE: en_q[axis_idx] <= 1'b0;
						CMD_HOME: begin
							if (safety == STAT_OK) begin
								pos_q[axis_idx]   <= '0;
								homed_q[axis_idx] <= 1'b1;
								mode_q[axis_idx]  <= MODE_IDLE;
								lim_q[axis_idx]   <= LIM_NONE;
							end
						end
						CMD_JOG: begin
							if (step_q == '0) begin
								jog_q[axis_idx]  <= '0;
								rep_q[axis_idx]  <= '0;
								mode_q[axis_idx] <= MODE_IDLE;
							end else if (apply_status == STAT_OK) begin
								jog_q[axis_idx]  <= step_q;
								mode_q[axis_idx] <= MODE_MOVING;
							end
						end
						CMD_STOP: begin
							jog_q[axis_idx]  <= '0;
							rep_q[axis_idx]  <= '0;
							mode_q[axis_idx] <= MODE_IDLE;
						end
						CMD_CLEAR_ALARM: begin
							if (cur_mode == MODE_ALARM) begin
								fault_q[axis_idx] <= LIM_NONE;
								lim_q[axis_idx]   <= LIM_NONE;
								mode_q[axis_idx]  <= MODE_IDLE;
							end
						end
						default: ;
					endcase
				end
				OP_EMIT: begin
					if (tick_go) begin
						pos_q[axis_idx]   <= nxt_pos;
						jog_q[axis_idx]   <= nxt_jog;
						rep_q[axis_idx]   <= nxt_rep;
						mode_q[axis_idx]  <= nxt_mode;
						lim_q[axis_idx]   <= nxt_lim;
						fault_q[axis_idx] <= nxt_fault;
					end
				end
				default: ;
			endcase
		end
	end

	// Load the result beat with the axis record as it stands after this step
	always_ff @(posedge clk) begin
		if (dp_cmd.op == OP_EMIT) begin
			o_status_q  <= status_q;
			o_axis_q    <= SEL_W'(axis_idx);
			o_mode_q    <= nxt_mode;
			o_pos_q     <= nxt_pos;
			o_vel_q     <= nxt_rep;
			o_limit_q   <= nxt_lim;
			o_fault_q   <= nxt_fault;
			o_enabled_q <= en_q[axis_idx];
			o_homed_q   <= homed_q[axis_idx];
			o_estop_q   <= estop_q;
			o_last_q    <= dp_cmd.last;
		end
	end

	assign o_status  = o_status_q;
	assign o_axis    = o_axis_q;
	assign o_mode    = o_mode_q;
	assign o_pos     = o_pos_q;
	assign o_vel     = o_vel_q;
	assign o_limit   = o_limit_q;
	assign o_fault   = o_fault_q;
	assign o_enabled = o_enabled_q;
	assign o_homed   = o_homed_q;
	assign o_estop   = o_estop_q;
	assign o_last    = o_last_q;

endmodule

// ===== sv/three_axis_jog_motion_supervisor.sv =====
// Jog motion supervisor for NUM_AXES axes: takes one command beat at a time and answers
// with one result beat per reported axis (all axes for tick, open, close, estop and
// reset estop; the addressed axis for the rest; none for an unknown command or an axis
// select out of range), the last beat of a run marked by last_of_run. A tick goes
// from accept straight to emit; the single add-and-compare unit moves one axis record
// a cycle while that axis's beat is loaded, unless the result output stalls. Any other
// command steps through accept, update and emit. A stalled result output holds the emit
// step in place. Soft limits and the step bound must only be written by the user through
// cfg_we/cfg_index/cfg_data while no command is in flight; the block does not enforce it.
module three_axis_jog_motion_supervisor #(
	parameter int NUM_AXES   = 3,
	parameter int POS_WIDTH  = 32,
	parameter int STEP_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	tjms_in_if.sink                             item,
	tjms_out_if.source                          result,
	input  logic                                cfg_we,
	input  logic [tjms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [((POS_WIDTH > tjms_pkg::MAX_STEP_W) ?
		POS_WIDTH : tjms_pkg::MAX_STEP_W)-1:0]  cfg_data
);
	import tjms_pkg::*;

	localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam int CFG_W = (POS_WIDTH > MAX_STEP_W) ? POS_WIDTH : MAX_STEP_W;

	dp_cmd_t          dp_cmd;
	logic [IDX_W-1:0] axis_idx;

	tjms_ctrl #(
		.NUM_AXES (NUM_AXES),
		.IDX_W    (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_cmd    (item.cmd),
		.in_sel    (item.axis_sel),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.dp_cmd    (dp_cmd),
		.axis_idx  (axis_idx)
	);

	tjms_dp #(
		.NUM_AXES   (NUM_AXES),
		.POS_WIDTH  (POS_WIDTH),
		.STEP_WIDTH (STEP_WIDTH),
		.IDX_W      (IDX_W),
		.CFG_W      (CFG_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.dp_cmd    (dp_cmd),
		.axis_idx  (axis_idx),
		.in_step   (item.jog_step),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.o_status  (result.status),
		.o_axis    (result.axis_id),
		.o_mode    (result.axis_mode),
		.o_pos     (result.position),
		.o_vel     (result.velocity),
		.o_limit   (result.limit_flag),
		.o_fault   (result.fault_code),
		.o_enabled (result.enabled),
		.o_homed   (result.homed),
		.o_estop   (result.estop_flag),
		.o_last    (result.last_of_run)
	);

endmodule
